[rtl/spimw_pkg.sv]
// Shared types and constants for the SPI write-then-read master.
`timescale 1ns / 1ps
`default_nettype none
package spimw_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned CNT_W   = 6;
  localparam int unsigned TIMER_W = 16;
  localparam logic [TIMER_W-1:0] TPU_RESET = 16'd100;

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_SETUP  = 6'b000010,
    PH_WRITE  = 6'b000100,
    PH_GAP    = 6'b001000,
    PH_READ   = 6'b010000,
    PH_FINISH = 6'b100000
  } phase_t;

  localparam logic [1:0] STEP_LAST = 2'd3;

  // Sequencer state apart from the shift registers
  typedef struct packed {
    phase_t             phase;
    logic [TIMER_W-1:0] timer;
    logic [1:0]         step;
    logic [CNT_W-1:0]   bitcnt;
    logic [CNT_W-1:0]   write_len;
    logic [CNT_W-1:0]   read_len;
  } seq_state_t;

  // One result item
  typedef struct packed {
    logic [WORD_W-1:0] read_word;
    logic              done;
    logic              busy;
    logic              select_n;
    logic              mosi;
    logic              sclk;
  } result_t;

endpackage
`default_nettype wire

[rtl/spimw_step.sv]
// Per-tick next-state and pin logic of the SPI sequencer.
`timescale 1ns / 1ps
`default_nettype none
module spimw_step
  import spimw_pkg::*;
#(
  parameter int unsigned MAX_BITS = 32
) (
  input  seq_state_t          cur,
  input  logic [MAX_BITS-1:0] tx_cur,
  input  logic [MAX_BITS-1:0] rx_cur,
  input  logic                cmd,
  input  logic [WORD_W-1:0]   send_word,
  input  logic [CNT_W-1:0]    write_count,
  input  logic [CNT_W-1:0]    read_count,
  input  logic                miso,
  input  logic [TIMER_W-1:0]  ticks_per_unit,
  output seq_state_t          nxt,
  output logic [MAX_BITS-1:0] tx_nxt,
  output logic [MAX_BITS-1:0] rx_nxt,
  output result_t             res
);

  localparam int unsigned IDX_W = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;
  localparam logic [CNT_W:0] MAX_LEN = (CNT_W+1)'(MAX_BITS);

  function automatic logic [CNT_W-1:0] clamp_len(input logic [CNT_W-1:0] v);
    logic [CNT_W:0] w;
    begin
      w = {1'b0, v};
      clamp_len = (w > MAX_LEN) ? MAX_LEN[CNT_W-1:0] : v;
    end
  endfunction

  seq_state_t          s;
  logic [MAX_BITS-1:0] tx_s;
  logic [MAX_BITS-1:0] rx_s;
  logic [MAX_BITS-1:0] tx_load;
  logic [WORD_W-1:0]   rx_low;
  logic [TIMER_W-1:0]  unit;
  logic [TIMER_W:0]    timer_inc;
  logic                unit_end;
  logic [CNT_W-1:0]    bit_idx;
  logic [CNT_W-1:0]    cnt_dec;

  generate
    if (MAX_BITS > WORD_W) begin : g_wide
      assign tx_load = {{(MAX_BITS-WORD_W){1'b0}}, send_word};
      assign rx_low  = rx_s[WORD_W-1:0];
    end else if (MAX_BITS == WORD_W) begin : g_equal
      assign tx_load = send_word;
      assign rx_low  = rx_s;
    end else begin : g_narrow
      assign tx_load = send_word[MAX_BITS-1:0];
      assign rx_low  = {{(WORD_W-MAX_BITS){1'b0}}, rx_s};
    end
  endgenerate

  // Start command is only seen in idle; the start tick is the first setup tick
  always_comb begin
    s    = cur;
    tx_s = tx_cur;
    rx_s = rx_cur;
    if (cur.phase == PH_IDLE && cmd) begin
      tx_s        = tx_load;
      rx_s        = '0;
      s.write_len = clamp_len(write_count);
      s.read_len  = clamp_len(read_count);
      s.phase     = PH_SETUP;
      s.timer     = '0;
      s.step      = '0;
      s.bitcnt    = '0;
    end
  end

  assign unit      = (ticks_per_unit == '0) ? TIMER_W'(1) : ticks_per_unit;
  assign timer_inc = {1'b0, s.timer} + (TIMER_W+1)'(1);
  assign unit_end  = timer_inc >= {1'b0, unit};
  assign bit_idx   = s.bitcnt - CNT_W'(1);
  assign cnt_dec   = (s.bitcnt != '0) ? s.bitcnt - CNT_W'(1) : '0;

  always_comb begin
    res          = '0;
    res.select_n = 1'b1;
    case (s.phase)
      PH_SETUP: res.busy = 1'b1;
      PH_WRITE: begin
        res.busy     = 1'b1;
        res.select_n = 1'b0;
        res.sclk     = (s.step == 2'd1) || (s.step == 2'd2);
        res.mosi     = (s.bitcnt != '0) ? tx_s[bit_idx[IDX_W-1:0]] : 1'b0;
      end
      PH_GAP: begin
        res.busy     = 1'b1;
        res.select_n = 1'b0;
      end
      PH_READ: begin
        res.busy     = 1'b1;
        res.select_n = 1'b0;
        res.sclk     = (s.step <= 2'd1);
      end
      PH_FINISH: begin
        res.busy = 1'b1;
        if (unit_end) begin
          res.done      = 1'b1;
          res.read_word = rx_low;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    nxt    = s;
    tx_nxt = tx_s;
    rx_nxt = rx_s;
    if (s.phase != PH_IDLE) begin
      if (!unit_end) begin
        nxt.timer = timer_inc[TIMER_W-1:0];
      end else begin
        nxt.timer = '0;
        case (s.phase)
          PH_SETUP: begin
            if (s.write_len != '0) begin
              nxt.phase  = PH_WRITE;
              nxt.step   = '0;
              nxt.bitcnt = s.write_len;
            end else begin
              nxt.phase = PH_GAP;
            end
          end
          PH_WRITE: begin
            if (s.step == STEP_LAST) begin
              nxt.step   = '0;
              nxt.bitcnt = cnt_dec;
              if (cnt_dec == '0) nxt.phase = PH_GAP;
            end else begin
              nxt.step = s.step + 2'd1;
            end
          end
          PH_GAP: begin
            if (s.read_len != '0) begin
              nxt.phase  = PH_READ;
              nxt.step   = '0;
              nxt.bitcnt = s.read_len;
            end else begin
              nxt.phase = PH_FINISH;
            end
          end
          PH_READ: begin
            // MISO sampled at the end of the first clock-high unit
            if (s.step == 2'd0) begin
              if (MAX_BITS > 1) rx_nxt = {rx_s[MAX_BITS-2:0], miso} & {MAX_BITS{1'b1}};
              else rx_nxt = MAX_BITS'(miso);
            end
            if (s.step == STEP_LAST) begin
              nxt.step   = '0;
              nxt.bitcnt = cnt_dec;
              if (cnt_dec == '0) nxt.phase = PH_FINISH;
            end else begin
              nxt.step = s.step + 2'd1;
            end
          end
          default: begin
            nxt.phase  = PH_IDLE;
            nxt.step   = '0;
            nxt.bitcnt = '0;
          end
        endcase
      end
    end
  end

endmodule
`default_nettype wire

[rtl/spimw_oreg.sv]
// Result register between the sequencer and the output stream.
`timescale 1ns / 1ps
`default_nettype none
module spimw_oreg
  import spimw_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load_valid,
  output logic    load_ready,
  input  result_t load_res,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res_q
);

  logic    valid_r;
  result_t res_r;

  // Refill in the same cycle the held result is taken
  assign load_ready = !valid_r || res_ready;
  assign res_valid  = valid_r;
  assign res_q      = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load_ready) begin
      valid_r <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ready && load_valid) begin
      res_r <= load_res;
    end
  end

endmodule
`default_nettype wire

[rtl/spi_master_write_then_read.sv]
// Top level: tick-driven SPI master, mode 0, MSB first, write then read.
// A tick's result is registered and offered in the cycle after its transfer is accepted.
// One tick per cycle while the output stream does not stall; the state update and pin logic are combinational.
// Reset (synchronous, rst_n low): sequencer idle, select high, clock and data low,
// output stream empty, ticks_per_unit back to 100.
`timescale 1ns / 1ps
`default_nettype none
module spi_master_write_then_read
  import spimw_pkg::*;
#(
  parameter int unsigned MAX_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [31:0] send_word, [37:32] write_count, [43:38] read_count, [44] miso_level
  input  logic [47:0] in_tdata,
  // [0] cmd
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] sclk_level, [1] mosi_level, [2] select_n, [3] busy_res, [35:4] read_word
  output logic [39:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic [TIMER_W-1:0]  tpu_r;
  seq_state_t          st_r, st_nxt;
  logic [MAX_BITS-1:0] tx_r, tx_nxt;
  logic [MAX_BITS-1:0] rx_r, rx_nxt;
  result_t             step_res;
  result_t             out_res;
  logic                in_acc;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpu_r <= TPU_RESET;
    end else if (cfg_valid && cfg_ready) begin
      tpu_r <= cfg_data;
    end
  end

  spimw_step #(
    .MAX_BITS(MAX_BITS)
  ) u_step (
    .cur           (st_r),
    .tx_cur        (tx_r),
    .rx_cur        (rx_r),
    .cmd           (in_tuser),
    .send_word     (in_tdata[31:0]),
    .write_count   (in_tdata[37:32]),
    .read_count    (in_tdata[43:38]),
    .miso          (in_tdata[44]),
    .ticks_per_unit(tpu_r),
    .nxt           (st_nxt),
    .tx_nxt        (tx_nxt),
    .rx_nxt        (rx_nxt),
    .res           (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase     <= PH_IDLE;
      st_r.timer     <= '0;
      st_r.step      <= '0;
      st_r.bitcnt    <= '0;
      st_r.write_len <= '0;
      st_r.read_len  <= '0;
      tx_r           <= '0;
      rx_r           <= '0;
    end else if (in_acc) begin
      st_r <= st_nxt;
      tx_r <= tx_nxt;
      rx_r <= rx_nxt;
    end
  end

  spimw_oreg u_oreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_valid(in_tvalid),
    .load_ready(in_tready),
    .load_res  (step_res),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res_q     (out_res)
  );

  assign out_tdata = {4'b0000, out_res.read_word, out_res.busy, out_res.select_n,
                      out_res.mosi, out_res.sclk};
  assign out_tlast = out_res.done;

  // Done only ever comes inside a transfer
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[3])
    else $error("done without busy");

  // Read word is zero except on the done tick
  a_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[35:4] == '0)
    else $error("read word outside done");

  // Select is only low while busy
  a_sel_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[2] |-> out_tdata[3])
    else $error("select low while idle");

  // A plain tick in idle leaves the sequencer idle
  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_tuser && st_r.phase == PH_IDLE |=> st_r.phase == PH_IDLE)
    else $error("left idle without start");

endmodule
`default_nettype wire
